// ===== src/uls_pkg.sv =====
// Package for the unordered list store: item types, command and status codes,
// and the control and status bundles between controller and datapath.
// No dependencies.
package uls_pkg;

  // Default number of list entries
  localparam int DEF_CAPACITY = 16;

  // Command codes of an input item
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Status codes of a result item
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Result kinds picked by the controller
  localparam logic [2:0] RES_INS_OK    = 3'd0;
  localparam logic [2:0] RES_FULL      = 3'd1;
  localparam logic [2:0] RES_NOT_FOUND = 3'd2;
  localparam logic [2:0] RES_HIT       = 3'd3;
  localparam logic [2:0] RES_DEL       = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] fill_count;
  } res_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       ld_item;   // latch the search value
    logic       idx_clr;
    logic       idx_inc;
    logic       hit_ld;    // remember the match index
    logic       rd_next;   // read address idx+1 instead of idx
    logic       wr_insert; // write request value at the fill position
    logic       wr_shift;  // write read data at idx
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_ld;
    logic [2:0] res_kind;
  } uls_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_cmd;
    logic       empty;
    logic       full;
    logic       match;      // read data equals the latched value
    logic       last_scan;  // idx is the last valid entry
    logic       shift_more; // another entry remains to move left
  } uls_stat_t;

endpackage

// ===== src/uls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/uls_datapath.sv =====
// Datapath of the unordered list store: entry RAM, fill count, scan index,
// compare and result register.
// Depends on uls_pkg and uls_ram.
module uls_datapath import uls_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t request,
  input  uls_ctrl_t ctrl,
  output uls_stat_t stat,
  output res_item_t result,
  output logic      done
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 2;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] idx;
  logic [IW-1:0] hit;
  logic [31:0]   value;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [31:0]   pos_wide;
  logic [31:0]   fill_wide;
  res_item_t     res_next;

  // Entry store
  uls_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Write and read port muxing
  always_comb begin
    ram_we    = ctrl.wr_insert | ctrl.wr_shift;
    ram_waddr = ctrl.wr_insert ? IW'(count) : idx;
    ram_wdata = ctrl.wr_insert ? $unsigned(request.value) : ram_rdata;
    ram_raddr = ctrl.rd_next ? IW'(XW'(idx) + XW'(1)) : idx;
  end

  // Status to the controller
  always_comb begin
    stat.in_cmd     = request.command;
    stat.empty      = (count == '0);
    stat.full       = (count >= CW'(CAPACITY));
    stat.match      = (ram_rdata == value);
    stat.last_scan  = ((XW'(idx) + XW'(1)) >= XW'(count));
    stat.shift_more = ((XW'(idx) + XW'(2)) < XW'(count));
  end

  // Fill count
  always_comb begin
    count_next = count;
    if (ctrl.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (ctrl.cnt_dec) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Scan index, match index and latched value
  always_ff @(posedge clk) begin
    if (ctrl.idx_clr) begin
      idx <= '0;
    end else if (ctrl.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (ctrl.hit_ld) begin
      hit <= idx;
    end
    if (ctrl.ld_item) begin
      value <= $unsigned(request.value);
    end
  end

  // Result formatting
  always_comb begin
    pos_wide  = '0;
    fill_wide = 32'(count_next);
    res_next.status = ST_OK;
    case (ctrl.res_kind)
      RES_INS_OK: pos_wide = 32'(count);
      RES_HIT:    pos_wide = 32'(idx);
      RES_DEL:    pos_wide = 32'(hit);
      RES_FULL:   res_next.status = ST_FULL;
      default:    res_next.status = ST_NOT_FOUND;
    endcase
    res_next.position   = pos_wide[3:0];
    res_next.fill_count = fill_wide[4:0];
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (ctrl.res_ld) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.res_ld;
    end
  end

endmodule

// ===== src/uls_ctrl.sv =====
// Controller of the unordered list store: sequences insert, linear search
// and the left shift of delete. Depends on uls_pkg.
module uls_ctrl import uls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  uls_stat_t stat,
  output uls_ctrl_t ctrl,
  output logic      busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_SH_READ  = 3'd3;
  localparam logic [2:0] S_SH_WRITE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] cmd;
  logic [1:0] cmd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= CMD_INSERT;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    ctrl       = '0;
    ctrl.res_kind = RES_NOT_FOUND;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next = stat.in_cmd;
          case (stat.in_cmd) inside
            CMD_INSERT: begin
              ctrl.res_ld = 1'b1;
              if (stat.full) begin
                ctrl.res_kind = RES_FULL;
              end else begin
                ctrl.wr_insert = 1'b1;
                ctrl.cnt_inc   = 1'b1;
                ctrl.res_kind  = RES_INS_OK;
              end
            end
            CMD_SEARCH, CMD_DELETE: begin
              ctrl.ld_item = 1'b1;
              ctrl.idx_clr = 1'b1;
              if (stat.empty) begin
                ctrl.res_ld = 1'b1;
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              ctrl.res_ld = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.match) begin
          if (cmd == CMD_SEARCH) begin
            ctrl.res_ld   = 1'b1;
            ctrl.res_kind = RES_HIT;
            state_next    = S_IDLE;
          end else begin
            ctrl.hit_ld = 1'b1;
            if (stat.last_scan) begin
              // match on the last entry: nothing to move
              ctrl.cnt_dec  = 1'b1;
              ctrl.res_ld   = 1'b1;
              ctrl.res_kind = RES_HIT;
              state_next    = S_IDLE;
            end else begin
              ctrl.rd_next = 1'b1;
              state_next   = S_SH_READ;
            end
          end
        end else if (stat.last_scan) begin
          ctrl.res_ld = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next   = S_READ;
        end
      end
      S_SH_READ: begin
        // read of entry idx+1 in flight
        ctrl.rd_next = 1'b1;
        state_next   = S_SH_WRITE;
      end
      S_SH_WRITE: begin
        ctrl.wr_shift = 1'b1;
        if (stat.shift_more) begin
          ctrl.idx_inc = 1'b1;
          state_next   = S_SH_READ;
        end else begin
          ctrl.cnt_dec  = 1'b1;
          ctrl.res_ld   = 1'b1;
          ctrl.res_kind = RES_DEL;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // read address follows the index of the next read
    if (state_next == S_SH_READ) begin
      ctrl.rd_next = 1'b1;
    end
  end

endmodule

// ===== src/unordered_list_store_top.sv =====
// Unordered list store: insert is done in the idle state; search passes S_READ
// and S_CHECK per entry scanned; delete adds S_SH_READ and S_SH_WRITE per entry
// moved left. Result appears the cycle after the operation ends with done high
// for one cycle. A new item is taken whenever busy is low, also while done is
// high. Rate is set by the single read port of the entry RAM. Synchronous reset
// empties the list at once. Depends on uls_pkg, uls_ctrl and uls_datapath.
module unordered_list_store_top import uls_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  req_item_t request,
  output logic      busy,
  output res_item_t result,
  output logic      done
);

  uls_ctrl_t ctrl;
  uls_stat_t stat;

  // Sequencer
  uls_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  // Storage, compare and result
  uls_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

endmodule
